// File: rtl/pfld_pkg.sv
// Shared types and constants for the priority FIFO/LIFO dispatcher.
// Used by pfld_store, pfld_log and priority_fifo_lifo_dispatcher; no dependencies.
package pfld_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int STACK_DEPTH = 64;
  localparam int LOG_DEPTH   = 128;

  localparam int QA_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int SC_W = $clog2(STACK_DEPTH + 1);
  localparam int LA_W = $clog2(LOG_DEPTH);
  localparam int LC_W = $clog2(LOG_DEPTH + 1);

  localparam int ID_W    = 32;
  localparam int TIME_W  = 32;
  localparam int ENTRY_W = ID_W + TIME_W;

  localparam logic [1:0] CMD_SUBMIT   = 2'd0;
  localparam logic [1:0] CMD_DISPATCH = 2'd1;
  localparam logic [1:0] CMD_LOOKUP   = 2'd2;

  typedef enum logic [2:0] {
    STAT_ACCEPTED  = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_DISP_HIGH = 3'd2,
    STAT_DISP_LOW  = 3'd3,
    STAT_EMPTY     = 3'd4,
    STAT_LOG_FULL  = 3'd5,
    STAT_FOUND     = 3'd6,
    STAT_NOT_FOUND = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_SEARCH
  } fsm_t;

  // Requests to the task store: one push or one pop per cycle.
  typedef struct packed {
    logic push;
    logic pop;
    logic prio;
  } store_req_t;

  typedef struct packed {
    logic high_empty;
    logic high_full;
    logic low_empty;
    logic low_full;
  } store_stat_t;

  typedef struct packed {
    logic            wr;
    logic            rd;
    logic [LA_W-1:0] rd_addr;
  } log_req_t;

  typedef struct packed {
    logic                     prio;
    logic signed [ID_W-1:0]   id;
    logic        [TIME_W-1:0] created;
    logic        [TIME_W-1:0] completed;
  } log_entry_t;

  typedef struct packed {
    logic            full;
    logic [LC_W-1:0] count;
  } log_stat_t;

endpackage

// File: rtl/priority_fifo_lifo_dispatcher.sv
// Two-level strict-priority dispatcher: control sequencer over the task store and log.
// Submit, a refused dispatch and a lookup in an empty log are answered from the execute state;
// a dispatch pops there and logs in the pop-wait state; a lookup scans from log entry zero to
// the first match or the last entry. One transaction at a time; a lookup reads the log memory
// one entry per cycle through its single read port. busy drops in the cycle the result strobe
// is high. The receiver cannot stall. Synchronous active-low reset empties the FIFO, stack, log.
module priority_fifo_lifo_dispatcher (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_cmd,
  input  logic signed [pfld_pkg::ID_W-1:0]    in_task_id,
  input  logic                                in_priority_req,
  input  logic [pfld_pkg::TIME_W-1:0]         in_now,
  output logic                                out_valid,
  output logic [2:0]                          out_status,
  output logic signed [pfld_pkg::ID_W-1:0]    out_id,
  output logic                                out_priority,
  output logic [pfld_pkg::TIME_W-1:0]         out_created,
  output logic [pfld_pkg::TIME_W-1:0]         out_completed
);
  import pfld_pkg::*;

  fsm_t                     state_r, state_nxt;
  logic [1:0]               cmd_r;
  logic signed [ID_W-1:0]   id_r;
  logic                     prio_r;
  logic [TIME_W-1:0]        now_r;
  logic                     tp_r;
  logic [LA_W-1:0]          idx_r, idx_nxt;

  store_req_t               st_req;
  store_stat_t              st_stat;
  logic [ENTRY_W-1:0]       st_rdata;
  log_req_t                 lg_req;
  log_stat_t                lg_stat;
  log_entry_t               lg_wdata;
  log_entry_t               lg_rdata;

  logic                     res_load;
  status_t                  res_status;
  logic signed [ID_W-1:0]   res_id;
  logic                     res_prio;
  logic [TIME_W-1:0]        res_created;
  logic [TIME_W-1:0]        res_completed;

  status_t                  status_r;
  logic                     valid_r;
  logic signed [ID_W-1:0]   oid_r;
  logic                     oprio_r;
  logic [TIME_W-1:0]        ocreated_r;
  logic [TIME_W-1:0]        ocompleted_r;

  logic                     accept;
  logic                     stores_empty;
  logic                     match;
  logic                     last_entry;

  assign busy         = (state_r != S_IDLE);
  assign accept       = start && !busy;
  assign stores_empty = st_stat.high_empty && st_stat.low_empty;
  assign match        = (lg_rdata.id == id_r);
  assign last_entry   = ((LC_W'(idx_r) + LC_W'(1)) == lg_stat.count);

  pfld_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (st_req),
    .wdata ({now_r, id_r}),
    .stat  (st_stat),
    .rdata (st_rdata)
  );

  pfld_log u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (lg_req),
    .wdata (lg_wdata),
    .stat  (lg_stat),
    .rdata (lg_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (cmd_r == CMD_DISPATCH && !stores_empty && !lg_stat.full) begin
          state_nxt = S_POP_WAIT;
        end else if (cmd_r == CMD_LOOKUP && lg_stat.count != '0) begin
          state_nxt = S_SEARCH;
        end
      end
      S_POP_WAIT: begin
        state_nxt = S_IDLE;
      end
      S_SEARCH: begin
        if (match || last_entry) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output and datapath control.
  always_comb begin
    st_req            = '0;
    st_req.prio       = prio_r;
    lg_req            = '0;
    lg_wdata.prio     = tp_r;
    lg_wdata.id       = st_rdata[ID_W-1:0];
    lg_wdata.created  = st_rdata[ENTRY_W-1:ID_W];
    lg_wdata.completed = now_r;
    idx_nxt           = idx_r;
    res_load          = 1'b0;
    res_status        = STAT_NOT_FOUND;
    res_id            = '0;
    res_prio          = 1'b0;
    res_created       = '0;
    res_completed     = '0;
    unique case (state_r)
      S_IDLE: begin
      end
      S_EXEC: begin
        unique case (cmd_r)
          CMD_SUBMIT: begin
            res_load = 1'b1;
            if ((prio_r && st_stat.high_full) || (!prio_r && st_stat.low_full)) begin
              res_status = STAT_FULL;
            end else begin
              st_req.push = 1'b1;
              res_status  = STAT_ACCEPTED;
            end
          end
          CMD_DISPATCH: begin
            // Empty stores are reported ahead of a full log.
            if (stores_empty) begin
              res_load   = 1'b1;
              res_status = STAT_EMPTY;
            end else if (lg_stat.full) begin
              res_load   = 1'b1;
              res_status = STAT_LOG_FULL;
            end else begin
              st_req.pop = 1'b1;
            end
          end
          CMD_LOOKUP: begin
            if (lg_stat.count == '0) begin
              res_load = 1'b1;
            end else begin
              lg_req.rd      = 1'b1;
              lg_req.rd_addr = '0;
              idx_nxt        = '0;
            end
          end
          default: begin
            res_load = 1'b1;
          end
        endcase
      end
      S_POP_WAIT: begin
        lg_req.wr     = 1'b1;
        res_load      = 1'b1;
        res_status    = tp_r ? STAT_DISP_HIGH : STAT_DISP_LOW;
        res_id        = st_rdata[ID_W-1:0];
        res_prio      = tp_r;
        res_created   = st_rdata[ENTRY_W-1:ID_W];
        res_completed = now_r;
      end
      S_SEARCH: begin
        // Compare the entry read last cycle while fetching the next one.
        if (match) begin
          res_load      = 1'b1;
          res_status    = STAT_FOUND;
          res_id        = id_r;
          res_prio      = lg_rdata.prio;
          res_created   = lg_rdata.created;
          res_completed = lg_rdata.completed;
        end else if (last_entry) begin
          res_load = 1'b1;
        end else begin
          lg_req.rd      = 1'b1;
          lg_req.rd_addr = idx_r + LA_W'(1);
          idx_nxt        = idx_r + LA_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      id_r   <= in_task_id;
      prio_r <= in_priority_req;
      now_r  <= in_now;
    end
    if (st_req.pop) begin
      tp_r <= !st_stat.high_empty;
    end
    idx_r <= idx_nxt;
    if (res_load) begin
      status_r     <= res_status;
      oid_r        <= res_id;
      oprio_r      <= res_prio;
      ocreated_r   <= res_created;
      ocompleted_r <= res_completed;
    end
  end

  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_id        = oid_r;
  assign out_priority  = oprio_r;
  assign out_created   = ocreated_r;
  assign out_completed = ocompleted_r;

  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result strobe without a transaction");
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while still busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("accepted transaction did not raise busy");

endmodule

// File: rtl/pfld_store.sv
// Task store: high-priority FIFO memory and low-priority stack memory with pointers.
// Depends on pfld_pkg.
module pfld_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pfld_pkg::store_req_t         req,
  input  logic [pfld_pkg::ENTRY_W-1:0] wdata,
  output pfld_pkg::store_stat_t        stat,
  output logic [pfld_pkg::ENTRY_W-1:0] rdata
);
  import pfld_pkg::*;

  logic [ENTRY_W-1:0] hq_mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] ls_mem [STACK_DEPTH];

  logic [QA_W-1:0]    head_r, head_nxt;
  logic [QA_W-1:0]    tail_r, tail_nxt;
  logic [QC_W-1:0]    hcnt_r, hcnt_nxt;
  logic [SC_W-1:0]    top_r, top_nxt;
  logic [ENTRY_W-1:0] hq_rd_r;
  logic [ENTRY_W-1:0] ls_rd_r;
  logic               src_hi_r;
  logic               push_hi, push_lo, pop_hi, pop_lo;
  logic [SA_W-1:0]    pop_addr;

  assign stat.high_empty = (hcnt_r == '0);
  assign stat.high_full  = (hcnt_r == QC_W'(QUEUE_DEPTH));
  assign stat.low_empty  = (top_r == '0);
  assign stat.low_full   = (top_r == SC_W'(STACK_DEPTH));

  // A pop always prefers the FIFO head over the stack top.
  assign push_hi  = req.push && req.prio;
  assign push_lo  = req.push && !req.prio;
  assign pop_hi   = req.pop && !stat.high_empty;
  assign pop_lo   = req.pop && stat.high_empty;
  assign pop_addr = SA_W'(top_r - SC_W'(1));

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    hcnt_nxt = hcnt_r;
    top_nxt  = top_r;
    if (push_hi) begin
      tail_nxt = (tail_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + QA_W'(1);
      hcnt_nxt = hcnt_r + QC_W'(1);
    end
    if (pop_hi) begin
      head_nxt = (head_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + QA_W'(1);
      hcnt_nxt = hcnt_r - QC_W'(1);
    end
    if (push_lo) begin
      top_nxt = top_r + SC_W'(1);
    end
    if (pop_lo) begin
      top_nxt = top_r - SC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      hcnt_r <= '0;
      top_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      hcnt_r <= hcnt_nxt;
      top_r  <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_hi) begin
      hq_mem[tail_r] <= wdata;
    end
    if (pop_hi) begin
      hq_rd_r <= hq_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (push_lo) begin
      ls_mem[top_r[SA_W-1:0]] <= wdata;
    end
    if (pop_lo) begin
      ls_rd_r <= ls_mem[pop_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.pop) begin
      src_hi_r <= !stat.high_empty;
    end
  end

  assign rdata = src_hi_r ? hq_rd_r : ls_rd_r;

  a_push_hi_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_hi |-> !stat.high_full) else $error("push to a full FIFO");
  a_push_lo_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_lo |-> !stat.low_full) else $error("push to a full stack");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    req.pop |-> !(stat.high_empty && stat.low_empty) && !req.push)
    else $error("pop from empty stores or overlapping push");

endmodule

// File: rtl/pfld_log.sv
// Completed-task log: one memory of finished entries with a fill count.
// Depends on pfld_pkg.
module pfld_log (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfld_pkg::log_req_t   req,
  input  pfld_pkg::log_entry_t wdata,
  output pfld_pkg::log_stat_t  stat,
  output pfld_pkg::log_entry_t rdata
);
  import pfld_pkg::*;

  log_entry_t      log_mem [LOG_DEPTH];
  logic [LC_W-1:0] count_r, count_nxt;

  assign stat.count = count_r;
  assign stat.full  = (count_r == LC_W'(LOG_DEPTH));
  assign count_nxt  = req.wr ? count_r + LC_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr) begin
      log_mem[count_r[LA_W-1:0]] <= wdata;
    end
    if (req.rd) begin
      rdata <= log_mem[req.rd_addr];
    end
  end

  a_wr_room: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr |-> !stat.full) else $error("write to a full log");
  a_rd_filled: assert property (@(posedge clk) disable iff (!rst_n)
    req.rd |-> (LC_W'(req.rd_addr) < count_r)) else $error("read of an unfilled log entry");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr |-> !req.rd) else $error("log read and write overlap");

endmodule

// File: test/tb_priority_fifo_lifo_dispatcher.sv
// Self-checking testbench for priority_fifo_lifo_dispatcher: a directed table, then bursty random
// transactions, each result checked against its typed row or a cycle-free FIFO, stack, log model.
// Depends on pfld_pkg and the dispatcher RTL only.
module tb_priority_fifo_lifo_dispatcher;
  timeunit 1ns;
  timeprecision 1ps;

  import pfld_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1080;
  localparam int SETTLE_CYCLES = LOG_DEPTH + 8;
  localparam int MAX_PRINTED = 60;

  typedef struct packed {
    status_t                  status;
    logic signed [ID_W-1:0]   id;
    logic                     prio;
    logic        [TIME_W-1:0] created;
    logic        [TIME_W-1:0] completed;
  } task_result_t;

  typedef struct {
    logic [1:0]               cmd;
    logic signed [ID_W-1:0]   id;
    logic                     prio;
    logic        [TIME_W-1:0] now;
    bit                       typed;
    task_result_t             res;
  } stim_row_t;

  localparam task_result_t NO_RESULT = '0;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [1:0]               in_cmd;
  logic signed [ID_W-1:0]   in_task_id;
  logic                     in_priority_req;
  logic        [TIME_W-1:0] in_now;
  logic                     out_valid;
  logic [2:0]               out_status;
  logic signed [ID_W-1:0]   out_id;
  logic                     out_priority;
  logic        [TIME_W-1:0] out_created;
  logic        [TIME_W-1:0] out_completed;

  priority_fifo_lifo_dispatcher uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_task_id     (in_task_id),
    .in_priority_req(in_priority_req),
    .in_now         (in_now),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_id         (out_id),
    .out_priority   (out_priority),
    .out_created    (out_created),
    .out_completed  (out_completed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model state: high FIFO, low stack and the completed log.
  logic [ENTRY_W-1:0]       fifo_mem [QUEUE_DEPTH];
  int                       fifo_head, fifo_tail, fifo_count;
  logic [ENTRY_W-1:0]       stack_mem [STACK_DEPTH];
  int                       stack_top;
  logic signed [ID_W-1:0]   done_id [LOG_DEPTH];
  logic                     done_prio [LOG_DEPTH];
  logic        [TIME_W-1:0] done_created [LOG_DEPTH];
  logic        [TIME_W-1:0] done_completed [LOG_DEPTH];
  int                       done_count;

  stim_row_t    directed_rows[$];
  task_result_t pending_results[$];
  int           mismatches;
  int           items_sent;
  int           results_seen;
  int           status_seen [8];
  int           burst_left;
  logic [TIME_W-1:0] tick;

  function automatic task_result_t predict_response(input logic [1:0] cmd,
                                                     input logic signed [ID_W-1:0] id,
                                                     input logic prio,
                                                     input logic [TIME_W-1:0] now);
    task_result_t       r;
    logic [ENTRY_W-1:0] entry;
    bit                 hit;
    r = '0;
    r.status = STAT_NOT_FOUND;
    hit = 1'b0;
    case (cmd)
      CMD_SUBMIT: begin
        entry = {now, id};
        if (prio) begin
          if (fifo_count >= QUEUE_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            fifo_mem[fifo_tail] = entry;
            fifo_tail = (fifo_tail + 1) % QUEUE_DEPTH;
            fifo_count++;
            r.status = STAT_ACCEPTED;
          end
        end else begin
          if (stack_top >= STACK_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            stack_mem[stack_top] = entry;
            stack_top++;
            r.status = STAT_ACCEPTED;
          end
        end
      end
      CMD_DISPATCH: begin
        if (fifo_count == 0 && stack_top == 0) begin
          r.status = STAT_EMPTY;
        end else if (done_count >= LOG_DEPTH) begin
          r.status = STAT_LOG_FULL;
        end else begin
          if (fifo_count != 0) begin
            entry = fifo_mem[fifo_head];
            fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
            fifo_count--;
            r.status = STAT_DISP_HIGH;
            r.prio = 1'b1;
          end else begin
            stack_top--;
            entry = stack_mem[stack_top];
            r.status = STAT_DISP_LOW;
            r.prio = 1'b0;
          end
          r.id = entry[ID_W-1:0];
          r.created = entry[ENTRY_W-1:ID_W];
          r.completed = now;
          done_id[done_count] = r.id;
          done_prio[done_count] = r.prio;
          done_created[done_count] = r.created;
          done_completed[done_count] = now;
          done_count++;
        end
      end
      CMD_LOOKUP: begin
        for (int i = 0; i < done_count && !hit; i++) begin
          if (done_id[i] == id) begin
            hit = 1'b1;
            r.status = STAT_FOUND;
            r.id = id;
            r.prio = done_prio[i];
            r.created = done_created[i];
            r.completed = done_completed[i];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Log ids for lookups, a small pool for duplicate ids, a few extremes, the rest fully random.
  function automatic logic signed [ID_W-1:0] pick_id(input bit from_log);
    int roll;
    roll = $urandom_range(0, 99);
    if (from_log && done_count > 0 && roll < 60)
      return done_id[$urandom_range(0, done_count - 1)];
    if (roll < 40)
      return $urandom_range(0, 15);
    if (roll < 50) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic void add_row(input logic [1:0] cmd, input logic signed [ID_W-1:0] id,
                                  input logic prio, input logic [TIME_W-1:0] now,
                                  input bit typed, input task_result_t res);
    stim_row_t row;
    row.cmd = cmd;
    row.id = id;
    row.prio = prio;
    row.now = now;
    row.typed = typed;
    row.res = res;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED)
      $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h expected %h",
                                results_seen, name, got, want));
  endtask

  // Holds start high until the block takes the transaction; start is left high.
  task automatic send_item(input stim_row_t row);
    task_result_t predicted;
    start <= 1'b1;
    in_cmd <= row.cmd;
    in_task_id <= row.id;
    in_priority_req <= row.prio;
    in_now <= row.now;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predicted = predict_response(row.cmd, row.id, row.prio, row.now);
    pending_results.push_back(row.typed ? row.res : predicted);
    items_sent++;
  endtask

  // Sender bursts: after a burst, start drops for a random gap with junk on the fields.
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      in_cmd <= 2'($urandom);
      in_task_id <= $urandom;
      in_priority_req <= 1'($urandom);
      in_now <= $urandom;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 16);
    end
  endtask

  always @(posedge clk) begin : result_checker
    task_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result strobe with no transaction outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(out_status), 32'(want.status));
        check_field("id", out_id, want.id);
        check_field("priority", 32'(out_priority), 32'(want.prio));
        check_field("created", out_created, want.created);
        check_field("completed", out_completed, want.completed);
        status_seen[want.status]++;
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    int               sub_pct [4];
    int               disp_pct [4];
    int               mode;
    int               block_left;
    int               high_bias;
    int               roll;
    int               waited;
    stim_row_t        row;
    sub_pct  = '{80, 15, 45, 20};
    disp_pct = '{10, 75, 35, 20};
    fifo_head = 0;
    fifo_tail = 0;
    fifo_count = 0;
    stack_top = 0;
    done_count = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    burst_left = 8;
    tick = '0;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_SUBMIT;
    in_task_id = '0;
    in_priority_req = 1'b0;
    in_now = '0;

    // Directed table. Typed expectations only where they are obvious.
    add_row(CMD_LOOKUP, 32'sd5, 1'b0, 32'd0, 1'b1,
            '{STAT_NOT_FOUND, 32'sd0, 1'b0, 32'd0, 32'd0});
    add_row(CMD_DISPATCH, 32'sd0, 1'b0, 32'd10, 1'b1,
            '{STAT_EMPTY, 32'sd0, 1'b0, 32'd0, 32'd0});
    add_row(CMD_UNUSED, -32'sd1, 1'b1, 32'hffff_ffff, 1'b1,
            '{STAT_NOT_FOUND, 32'sd0, 1'b0, 32'd0, 32'd0});
    add_row(CMD_SUBMIT, 32'sh7fff_ffff, 1'b1, 32'hffff_ffff, 1'b1,
            '{STAT_ACCEPTED, 32'sd0, 1'b0, 32'd0, 32'd0});
    add_row(CMD_SUBMIT, 32'sh8000_0000, 1'b0, 32'd0, 1'b1,
            '{STAT_ACCEPTED, 32'sd0, 1'b0, 32'd0, 32'd0});
    add_row(CMD_SUBMIT, -32'sd1, 1'b1, 32'd1, 1'b0, NO_RESULT);
    add_row(CMD_SUBMIT, 32'sd0, 1'b0, 32'h8000_0000, 1'b0, NO_RESULT);
    add_row(CMD_SUBMIT, 32'sh5a5a_5a5a, 1'b0, 32'h0000_abcd, 1'b0, NO_RESULT);
    add_row(CMD_SUBMIT, 32'sh7fff_ffff, 1'b1, 32'd2, 1'b0, NO_RESULT);
    add_row(CMD_DISPATCH, 32'sd0, 1'b0, 32'h1234_5678, 1'b1,
            '{STAT_DISP_HIGH, 32'sh7fff_ffff, 1'b1, 32'hffff_ffff, 32'h1234_5678});
    add_row(CMD_DISPATCH, 32'sd0, 1'b1, 32'd100, 1'b0, NO_RESULT);
    add_row(CMD_DISPATCH, 32'sd0, 1'b0, 32'd200, 1'b0, NO_RESULT);
    add_row(CMD_DISPATCH, -32'sd1, 1'b1, 32'd300, 1'b0, NO_RESULT);
    add_row(CMD_DISPATCH, 32'sd0, 1'b0, 32'hffff_ffff, 1'b0, NO_RESULT);
    add_row(CMD_LOOKUP, 32'sh7fff_ffff, 1'b0, 32'd0, 1'b0, NO_RESULT);
    add_row(CMD_LOOKUP, 32'sh8000_0000, 1'b1, 32'd0, 1'b0, NO_RESULT);
    add_row(CMD_DISPATCH, 32'sd0, 1'b0, 32'd0, 1'b0, NO_RESULT);
    add_row(CMD_LOOKUP, 32'sh8000_0000, 1'b0, 32'hffff_ffff, 1'b0, NO_RESULT);
    add_row(CMD_DISPATCH, 32'sd0, 1'b1, 32'd7, 1'b1,
            '{STAT_EMPTY, 32'sd0, 1'b0, 32'd0, 32'd0});
    add_row(CMD_LOOKUP, 32'sd0, 1'b0, 32'd0, 1'b0, NO_RESULT);
    add_row(CMD_LOOKUP, 32'sd12345, 1'b1, 32'd0, 1'b0, NO_RESULT);
    add_row(CMD_LOOKUP, -32'sd1, 1'b1, 32'd0, 1'b0, NO_RESULT);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i]);
      pace_sender();
    end

    // Random part in blocks of a dominant mix: fill, drain, balanced, lookup heavy.
    // The first block fills the FIFO so that full stores and pointer wrap come early.
    block_left = 0;
    mode = 0;
    high_bias = 90;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (block_left == 0) begin
        mode = (n == 0) ? 0 : $urandom_range(0, 3);
        block_left = (n == 0) ? 90 : $urandom_range(30, 90);
        case ((n == 0) ? 2 : $urandom_range(0, 2))
          0: high_bias = 10;
          1: high_bias = 50;
          default: high_bias = 90;
        endcase
      end
      block_left--;
      roll = $urandom_range(0, 99);
      if (roll < sub_pct[mode])
        row.cmd = CMD_SUBMIT;
      else if (roll < sub_pct[mode] + disp_pct[mode])
        row.cmd = CMD_DISPATCH;
      else if (roll < 98)
        row.cmd = CMD_LOOKUP;
      else
        row.cmd = CMD_UNUSED;
      row.id = pick_id(row.cmd == CMD_LOOKUP);
      if (row.cmd == CMD_SUBMIT)
        row.prio = ($urandom_range(0, 99) < high_bias);
      else
        row.prio = 1'($urandom_range(0, 1));
      tick = tick + $urandom_range(0, 50);
      roll = $urandom_range(0, 99);
      if (roll < 15)
        row.now = $urandom;
      else if (roll < 20)
        row.now = $urandom_range(0, 1) ? 32'hffff_ffff : 32'd0;
      else
        row.now = tick;
      row.typed = 1'b0;
      row.res = NO_RESULT;
      send_item(row);
      pace_sender();
    end
    start <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 4 * SETTLE_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    // Any stray strobe in this window is caught by the checker.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d transactions and %0d results; final log holds %0d of %0d entries.",
             items_sent, results_seen, done_count, LOG_DEPTH);
    $display("Seen: store full %0d, log full %0d, empty %0d, found %0d, not found %0d.",
             status_seen[STAT_FULL], status_seen[STAT_LOG_FULL], status_seen[STAT_EMPTY],
             status_seen[STAT_FOUND], status_seen[STAT_NOT_FOUND]);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: sim.f
rtl/pfld_pkg.sv
rtl/pfld_store.sv
rtl/pfld_log.sv
rtl/priority_fifo_lifo_dispatcher.sv
test/tb_priority_fifo_lifo_dispatcher.sv
